// File: rtl/rttp_pkg.sv
package rttp_pkg;

  // Parser phases. The order matters: the note phases sit at the top and are
  // compared by magnitude.
  typedef enum logic [3:0] {
    PH_NAME,
    PH_EXP_D,
    PH_D_EQ,
    PH_D_NUM,
    PH_EXP_O,
    PH_O_EQ,
    PH_O_DIG,
    PH_O_SEP,
    PH_EXP_B,
    PH_B_EQ,
    PH_B_NUM,
    PH_NOTE_START,
    PH_LETTER,
    PH_SHARP,
    PH_DOT,
    PH_SCALE
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  localparam logic [1:0] CFG_IDX_DUR = 2'd0;
  localparam logic [1:0] CFG_IDX_OCT = 2'd1;
  localparam logic [1:0] CFG_IDX_BPM = 2'd2;

  localparam logic [6:0] FB_DUR_RST = 7'd4;
  localparam logic [2:0] FB_OCT_RST = 3'd6;
  localparam logic [9:0] FB_BPM_RST = 10'd63;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_SHARP = 8'h23;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_3     = 8'h33;
  localparam logic [7:0] CHR_7     = 8'h37;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_LC_A  = 8'h61;
  localparam logic [7:0] CHR_LC_B  = 8'h62;
  localparam logic [7:0] CHR_LC_C  = 8'h63;
  localparam logic [7:0] CHR_LC_D  = 8'h64;
  localparam logic [7:0] CHR_LC_E  = 8'h65;
  localparam logic [7:0] CHR_LC_F  = 8'h66;
  localparam logic [7:0] CHR_LC_G  = 8'h67;
  localparam logic [7:0] CHR_LC_O  = 8'h6F;

  localparam logic [9:0]  ACC_MAX      = 10'd999;
  localparam logic [17:0] WHOLE_MS_NUM = 18'd60000;

  localparam int DIV_STEPS = 18;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // One unit of work for the back end: either a whole-note time update or a
  // finished note waiting for its duration division.
  typedef struct packed {
    logic       is_whole;
    logic [9:0] divisor;
    logic [3:0] note_code;
    logic [3:0] octave;
    logic       sharp;
    logic       dotted;
    logic       oct_dflt;
    logic       song_end;
  } job_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CHR_0) && (c <= CHR_9);
  endfunction

  function automatic logic [9:0] sat_accum(input logic [9:0] acc, input logic [7:0] c);
    logic [13:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {10'd0, c[3:0]};
    return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[9:0];
  endfunction

  function automatic logic [3:0] letter_code(input logic [7:0] c);
    logic [3:0] code;
    case (c)
      CHR_LC_C: code = 4'd1;
      CHR_LC_D: code = 4'd3;
      CHR_LC_E: code = 4'd5;
      CHR_LC_F: code = 4'd6;
      CHR_LC_G: code = 4'd8;
      CHR_LC_A: code = 4'd10;
      CHR_LC_B: code = 4'd12;
      default:  code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/rttp_front.sv
module rttp_front #(
  parameter int unsigned OCTAVE_SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        in_text_byte,
  input  logic              q_full,
  output logic              push,
  output rttp_pkg::job_t    push_job
);

  rttp_pkg::phase_t phase_r, phase_nxt;
  logic [9:0] acc_r, acc_nxt;
  logic [9:0] hdur_r, hdur_nxt;
  logic [2:0] hoct_r, hoct_nxt;
  logic [9:0] bpm_r, bpm_nxt;
  logic [3:0] pnote_r, pnote_nxt;
  logic       psharp_r, psharp_nxt;
  logic       pdot_r, pdot_nxt;
  logic [3:0] pocto_r, pocto_nxt;

  logic [6:0] fb_dur_r;
  logic [2:0] fb_oct_r;
  logic [9:0] fb_bpm_r;

  logic       accept;
  logic       start_req;
  logic [9:0] start_acc;
  logic [9:0] bpm_val;
  logic [7:0] c;

  assign accept = in_valid && !q_full;
  assign c      = in_text_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_dur_r <= rttp_pkg::FB_DUR_RST;
      fb_oct_r <= rttp_pkg::FB_OCT_RST;
      fb_bpm_r <= rttp_pkg::FB_BPM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rttp_pkg::CFG_IDX_DUR: fb_dur_r <= cfg_data[6:0];
        rttp_pkg::CFG_IDX_OCT: fb_oct_r <= cfg_data[2:0];
        rttp_pkg::CFG_IDX_BPM: fb_bpm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rttp_pkg::PH_NAME;
      acc_r    <= '0;
      hdur_r   <= {3'd0, rttp_pkg::FB_DUR_RST};
      hoct_r   <= rttp_pkg::FB_OCT_RST;
      bpm_r    <= rttp_pkg::FB_BPM_RST;
      pnote_r  <= '0;
      psharp_r <= 1'b0;
      pdot_r   <= 1'b0;
      pocto_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      hdur_r   <= hdur_nxt;
      hoct_r   <= hoct_nxt;
      bpm_r    <= bpm_nxt;
      pnote_r  <= pnote_nxt;
      psharp_r <= psharp_nxt;
      pdot_r   <= pdot_nxt;
      pocto_r  <= pocto_nxt;
    end
  end

  assign bpm_val = (acc_r != 10'd0) ? acc_r : fb_bpm_r;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    hdur_nxt   = hdur_r;
    hoct_nxt   = hoct_r;
    bpm_nxt    = bpm_r;
    pnote_nxt  = pnote_r;
    psharp_nxt = psharp_r;
    pdot_nxt   = pdot_r;
    pocto_nxt  = pocto_r;
    push       = 1'b0;
    push_job   = '0;
    start_req  = 1'b0;
    start_acc  = acc_r;

    if (accept) begin
      if (phase_r >= rttp_pkg::PH_LETTER) begin
        if (phase_r == rttp_pkg::PH_LETTER && c == rttp_pkg::CHR_SHARP) begin
          psharp_nxt = 1'b1;
          pnote_nxt  = pnote_r + 4'd1;
          phase_nxt  = rttp_pkg::PH_SHARP;
        end else if (phase_r <= rttp_pkg::PH_SHARP && c == rttp_pkg::CHR_DOT) begin
          pdot_nxt  = 1'b1;
          phase_nxt = rttp_pkg::PH_DOT;
        end else if (phase_r <= rttp_pkg::PH_DOT && rttp_pkg::is_dig(c)) begin
          pocto_nxt = c[3:0];
          phase_nxt = rttp_pkg::PH_SCALE;
        end else begin
          // Any other byte closes the note.
          push               = 1'b1;
          push_job.is_whole  = 1'b0;
          push_job.divisor   = (acc_r != 10'd0) ? acc_r : hdur_r;
          push_job.note_code = pnote_r;
          push_job.octave    = pocto_r + 4'(OCTAVE_SHIFT);
          push_job.sharp     = psharp_r;
          push_job.dotted    = pdot_r;
          push_job.oct_dflt  = (pocto_r == {1'b0, hoct_r});
          push_job.song_end  = (c == rttp_pkg::CHR_NUL);
          acc_nxt            = '0;
          if (c == rttp_pkg::CHR_NUL) begin
            phase_nxt = rttp_pkg::PH_NAME;
          end else begin
            phase_nxt = rttp_pkg::PH_NOTE_START;
            if (c != rttp_pkg::CHR_COMMA) begin
              start_req = 1'b1;
              start_acc = '0;
            end
          end
        end
      end else if (c == rttp_pkg::CHR_NUL) begin
        phase_nxt = rttp_pkg::PH_NAME;
        acc_nxt   = '0;
      end else begin
        case (phase_r)
          rttp_pkg::PH_NAME: begin
            if (c == rttp_pkg::CHR_COLON) begin
              hdur_nxt  = {3'd0, fb_dur_r};
              hoct_nxt  = fb_oct_r;
              bpm_nxt   = fb_bpm_r;
              acc_nxt   = '0;
              phase_nxt = rttp_pkg::PH_EXP_D;
            end
          end
          rttp_pkg::PH_D_EQ: begin
            acc_nxt   = '0;
            phase_nxt = rttp_pkg::PH_D_NUM;
          end
          rttp_pkg::PH_D_NUM: begin
            if (rttp_pkg::is_dig(c)) begin
              acc_nxt = rttp_pkg::sat_accum(acc_r, c);
            end else begin
              if (acc_r != 10'd0) hdur_nxt = acc_r;
              acc_nxt   = '0;
              phase_nxt = rttp_pkg::PH_EXP_O;
            end
          end
          rttp_pkg::PH_O_EQ: phase_nxt = rttp_pkg::PH_O_DIG;
          rttp_pkg::PH_O_DIG: begin
            if (c >= rttp_pkg::CHR_3 && c <= rttp_pkg::CHR_7) hoct_nxt = c[2:0];
            phase_nxt = rttp_pkg::PH_O_SEP;
          end
          rttp_pkg::PH_O_SEP: phase_nxt = rttp_pkg::PH_EXP_B;
          rttp_pkg::PH_B_EQ: begin
            acc_nxt   = '0;
            phase_nxt = rttp_pkg::PH_B_NUM;
          end
          rttp_pkg::PH_B_NUM: begin
            if (rttp_pkg::is_dig(c)) begin
              acc_nxt = rttp_pkg::sat_accum(acc_r, c);
            end else begin
              bpm_nxt           = bpm_val;
              push              = 1'b1;
              push_job.is_whole = 1'b1;
              push_job.divisor  = bpm_val;
              acc_nxt           = '0;
              phase_nxt         = rttp_pkg::PH_NOTE_START;
            end
          end
          rttp_pkg::PH_EXP_D, rttp_pkg::PH_EXP_O, rttp_pkg::PH_EXP_B: begin
            // A missing key falls through to the next one; past the last key
            // the byte starts the first note.
            if (phase_r == rttp_pkg::PH_EXP_D && c == rttp_pkg::CHR_LC_D) begin
              phase_nxt = rttp_pkg::PH_D_EQ;
            end else if (phase_r != rttp_pkg::PH_EXP_B && c == rttp_pkg::CHR_LC_O) begin
              phase_nxt = rttp_pkg::PH_O_EQ;
            end else if (c == rttp_pkg::CHR_LC_B) begin
              phase_nxt = rttp_pkg::PH_B_EQ;
            end else begin
              push              = 1'b1;
              push_job.is_whole = 1'b1;
              push_job.divisor  = bpm_r;
              acc_nxt           = '0;
              phase_nxt         = rttp_pkg::PH_NOTE_START;
              start_req         = 1'b1;
              start_acc         = '0;
            end
          end
          rttp_pkg::PH_NOTE_START: begin
            start_req = 1'b1;
            start_acc = acc_r;
          end
          default: ;
        endcase
      end

      if (start_req) begin
        if (rttp_pkg::is_dig(c)) begin
          acc_nxt = rttp_pkg::sat_accum(start_acc, c);
        end else begin
          pnote_nxt  = rttp_pkg::letter_code(c);
          psharp_nxt = 1'b0;
          pdot_nxt   = 1'b0;
          pocto_nxt  = {1'b0, hoct_r};
          phase_nxt  = rttp_pkg::PH_LETTER;
        end
      end
    end
  end

endmodule

// File: rtl/rttp_queue.sv
module rttp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rttp_pkg::job_t push_job,
  input  logic           pop,
  output rttp_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  rttp_pkg::job_t ent_r [rttp_pkg::QDEPTH];
  logic [rttp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rttp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rttp_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == rttp_pkg::QCNT_W'(rttp_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_job;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rttp_pkg::QCNT_W'(rttp_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/rttp_back.sv
module rttp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  rttp_pkg::job_t q_head,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [3:0]     out_note_code,
  output logic [3:0]     out_octave,
  output logic [18:0]    out_duration_ms,
  output logic           out_sharp_flag,
  output logic           out_dotted_flag,
  output logic           out_octave_is_default,
  output logic           out_song_end
);

  rttp_pkg::back_state_t state_r, state_nxt;
  rttp_pkg::job_t job_r, job_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [17:0] quo_r, quo_nxt;
  logic [rttp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [17:0] whole_r, whole_nxt;

  logic        ov_r, ov_nxt;
  logic [3:0]  on_r, on_nxt;
  logic [3:0]  oo_r, oo_nxt;
  logic [18:0] od_r, od_nxt;
  logic        os_r, os_nxt;
  logic        odt_r, odt_nxt;
  logic        odf_r, odf_nxt;
  logic        oe_r, oe_nxt;

  logic [10:0] r_sh;
  logic [11:0] diff;
  logic        ge;
  logic [17:0] q_fin;
  logic [18:0] dur_total;
  logic        out_free;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign r_sh = {rem_r, quo_r[17]};
  assign diff = {1'b0, r_sh} - {2'b0, job_r.divisor};
  assign ge   = !diff[11];

  assign q_fin     = (job_r.divisor == 10'd0) ? 18'd0 : quo_r;
  assign dur_total = {1'b0, q_fin} + (job_r.dotted ? {2'b0, q_fin[17:1]} : 19'd0);
  assign out_free  = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    whole_nxt = whole_r;
    ov_nxt    = ov_r && out_stall;
    on_nxt    = on_r;
    oo_nxt    = oo_r;
    od_nxt    = od_r;
    os_nxt    = os_r;
    odt_nxt   = odt_r;
    odf_nxt   = odf_r;
    oe_nxt    = oe_r;
    pop       = 1'b0;

    case (state_r)
      rttp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          job_nxt   = q_head;
          quo_nxt   = q_head.is_whole ? rttp_pkg::WHOLE_MS_NUM : whole_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = rttp_pkg::BK_DIV;
        end
      end
      rttp_pkg::BK_DIV: begin
        rem_nxt = ge ? diff[9:0] : r_sh[9:0];
        quo_nxt = {quo_r[16:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rttp_pkg::CNT_W'(rttp_pkg::DIV_STEPS - 1)) state_nxt = rttp_pkg::BK_DONE;
      end
      rttp_pkg::BK_DONE: begin
        if (job_r.is_whole) begin
          // The quotient of 60000 by the tempo fits in 16 bits.
          whole_nxt = {q_fin[15:0], 2'b00};
          state_nxt = rttp_pkg::BK_IDLE;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          on_nxt    = job_r.note_code;
          oo_nxt    = job_r.octave;
          od_nxt    = dur_total;
          os_nxt    = job_r.sharp;
          odt_nxt   = job_r.dotted;
          odf_nxt   = job_r.oct_dflt;
          oe_nxt    = job_r.song_end;
          state_nxt = rttp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rttp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rttp_pkg::BK_IDLE;
      whole_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      whole_r <= whole_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    on_r  <= on_nxt;
    oo_r  <= oo_nxt;
    od_r  <= od_nxt;
    os_r  <= os_nxt;
    odt_r <= odt_nxt;
    odf_r <= odf_nxt;
    oe_r  <= oe_nxt;
  end

  assign out_valid             = ov_r;
  assign out_note_code         = on_r;
  assign out_octave            = oo_r;
  assign out_duration_ms       = od_r;
  assign out_sharp_flag        = os_r;
  assign out_dotted_flag       = odt_r;
  assign out_octave_is_default = odf_r;
  assign out_song_end          = oe_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rttp_pkg::BK_DIV) |-> (cnt_r < rttp_pkg::CNT_W'(rttp_pkg::DIV_STEPS)))
    else $error("divider step count overran");
  a_whole_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rttp_pkg::BK_DONE && job_r.is_whole) |=> (state_r == rttp_pkg::BK_IDLE))
    else $error("tempo update did not retire in one cycle");

endmodule

// File: rtl/ringtone_text_note_parser_core.sv
// Channel | Direction | Handshake            | Beat carries
// in_     | input     | in_valid / in_stall  | in_text_byte
// out_    | output    | out_valid / out_stall| note code, octave, duration, flags
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The front end takes one text byte per cycle while its two-entry job queue has room.
// Each note or tempo update takes the back end through a load, 18 steps of the
// bit-serial restoring divider and a retire state; that divider sets the rate.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds its result while the divider works on the next job.
module ringtone_text_note_parser_core #(
  parameter int unsigned OCTAVE_SHIFT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_note_code,
  output logic [3:0]  out_octave,
  output logic [18:0] out_duration_ms,
  output logic        out_sharp_flag,
  output logic        out_dotted_flag,
  output logic        out_octave_is_default,
  output logic        out_song_end
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  rttp_pkg::job_t q_in;
  rttp_pkg::job_t q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  rttp_front #(
    .OCTAVE_SHIFT(OCTAVE_SHIFT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_text_byte(in_text_byte),
    .q_full      (q_full),
    .push        (q_push),
    .push_job    (q_in)
  );

  rttp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_in),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  rttp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .pop                  (q_pop),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_note_code        (out_note_code),
    .out_octave           (out_octave),
    .out_duration_ms      (out_duration_ms),
    .out_sharp_flag       (out_sharp_flag),
    .out_dotted_flag      (out_dotted_flag),
    .out_octave_is_default(out_octave_is_default),
    .out_song_end         (out_song_end)
  );

endmodule
